// File: hw/rtl/zero_run_rle_row_decoder_defines.svh
// Assertion macros shared by the checker of the row decoder.
`ifndef ZERO_RUN_RLE_ROW_DECODER_DEFINES_SVH
`define ZERO_RUN_RLE_ROW_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ZRRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ZRRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/zrrle_pkg.sv
// Types, constants and helper functions of the zero-run row decoder.
package zrrle_pkg;

    // Largest decoded row width and frame height.
    localparam int unsigned MAX_WIDTH   = 4095;
    localparam int unsigned MAX_HEIGHT  = 1023;

    // Bytes of the little-endian row length prefix.
    localparam int unsigned PREFIX_BYTES = 2;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DATA_LIMIT   = 2'd2;

    // Register reset values.
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [9:0]  RST_FRAME_HEIGHT = 10'd480;
    localparam logic [23:0] RST_DATA_LIMIT   = 24'd0;

    // Segment status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_NO_COUNT  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [9:0]  row_index;
        logic [11:0] column_start;
        logic [11:0] pixel_count;
        logic [7:0]  pixel_value;
        logic        row_end;
        logic        frame_end;
        logic [1:0]  status;
    } t_out_beat;

    // One classified byte: an optional pixel or error segment, then an optional row close.
    typedef struct packed {
        logic [9:0]  row;
        logic        seg_valid;
        logic [11:0] seg_col;
        logic [11:0] seg_cnt;
        logic [7:0]  seg_val;
        logic [1:0]  seg_status;
        logic        close_valid;
        logic [11:0] close_col;
        logic [11:0] close_cnt;
        logic        close_fe;
    } t_cmd;

    function automatic logic [11:0] eff_width(input logic [11:0] w);
        logic [11:0] r;
        r = w;
        if (32'(w) > MAX_WIDTH) r = 12'(MAX_WIDTH);
        return r;
    endfunction

    function automatic logic [9:0] eff_height(input logic [9:0] h);
        logic [9:0] r;
        r = h;
        if (32'(h) > MAX_HEIGHT) r = 10'(MAX_HEIGHT);
        return r;
    endfunction

    function automatic t_out_beat seg_beat(input t_cmd c);
        t_out_beat b;
        b.row_index    = c.row;
        b.column_start = c.seg_col;
        b.pixel_count  = c.seg_cnt;
        b.pixel_value  = c.seg_val;
        b.row_end      = 1'b0;
        b.frame_end    = 1'b0;
        b.status       = c.seg_status;
        return b;
    endfunction

    function automatic t_out_beat close_beat(input t_cmd c);
        t_out_beat b;
        b.row_index    = c.row;
        b.column_start = c.close_col;
        b.pixel_count  = c.close_cnt;
        b.pixel_value  = 8'd0;
        b.row_end      = 1'b1;
        b.frame_end    = c.close_fe;
        b.status       = ST_OK;
        return b;
    endfunction

endpackage

// File: hw/rtl/zrrle_queue.sv
// Small command queue between the decoder front and the output back.
module zrrle_queue
    import zrrle_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/zrrle_front.sv
// Decoder front: configuration registers and per-byte row parsing into commands.
module zrrle_front
    import zrrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_data,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_COUNT  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    logic [11:0] r_frame_width;
    logic [9:0]  r_frame_height;
    logic [23:0] r_data_limit;

    logic [2:0]  r_phase, n_phase;
    logic [9:0]  r_row, n_row;
    logic [11:0] r_col, n_col;
    logic [11:0] r_pl, n_pl;
    logic [15:0] r_rbl, n_rbl;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [23:0] r_br, n_br;
    logic        r_bounded, n_bounded;

    logic        w_accept;
    logic [2:0]  e_phase;
    logic [9:0]  e_row;
    logic [11:0] e_col, e_pl;
    logic [15:0] e_rbl, v_rbl_dec, v_len;
    logic [23:0] e_br;
    logic        e_bounded;
    logic [11:0] v_run;
    logic        v_close, v_fe;
    t_cmd        v_cmd;

    always_comb begin
        w_accept = i_in_valid && !i_full;

        // A frame start restarts the decoder before the byte is parsed.
        if (i_in_data.frame_start) begin
            e_phase   = PH_LEN_LO;
            e_row     = '0;
            e_col     = '0;
            e_pl      = '0;
            e_rbl     = '0;
            e_br      = r_data_limit;
            e_bounded = (r_data_limit != '0);
        end else begin
            e_phase   = r_phase;
            e_row     = r_row;
            e_col     = r_col;
            e_pl      = r_pl;
            e_rbl     = r_rbl;
            e_br      = r_br;
            e_bounded = r_bounded;
        end

        v_len     = {i_in_data.data_byte, r_len_lo};
        v_rbl_dec = e_rbl - 16'd1;
        v_run     = ({4'd0, i_in_data.data_byte} > e_pl) ? e_pl
                                                         : {4'd0, i_in_data.data_byte};
        v_fe      = ({1'b0, e_row} + 11'd1) >= {1'b0, eff_height(r_frame_height)};
        v_close   = 1'b0;
        v_cmd     = '0;
        v_cmd.row = e_row;

        n_phase   = r_phase;
        n_row     = r_row;
        n_col     = r_col;
        n_pl      = r_pl;
        n_rbl     = r_rbl;
        n_len_lo  = r_len_lo;
        n_br      = r_br;
        n_bounded = r_bounded;

        if (w_accept) begin
            n_phase   = e_phase;
            n_row     = e_row;
            n_col     = e_col;
            n_pl      = e_pl;
            n_rbl     = e_rbl;
            n_br      = e_br;
            n_bounded = e_bounded;

            case (e_phase)
                PH_LEN_LO: begin
                    if (e_bounded && (e_br < 24'(PREFIX_BYTES))) begin
                        v_cmd.seg_valid  = 1'b1;
                        v_cmd.seg_status = ST_EXHAUSTED;
                        n_phase          = PH_ERROR;
                    end else begin
                        n_len_lo = i_in_data.data_byte;
                        n_phase  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    if ((v_len < 16'(PREFIX_BYTES)) || (e_bounded && ({8'd0, v_len} > e_br)))
                    begin
                        v_cmd.seg_valid  = 1'b1;
                        v_cmd.seg_status = ST_BAD_LEN;
                        n_phase          = PH_ERROR;
                    end else begin
                        if (e_bounded) begin
                            n_br = e_br - {8'd0, v_len};
                        end
                        n_rbl = v_len - 16'(PREFIX_BYTES);
                        n_pl  = eff_width(r_frame_width);
                        n_col = '0;
                        if (n_rbl == '0) begin
                            v_close = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_rbl = v_rbl_dec;
                    if (i_in_data.data_byte != 8'd0) begin
                        // Literal pixel; drop it once the row is full.
                        if (e_pl != '0) begin
                            v_cmd.seg_valid = 1'b1;
                            v_cmd.seg_col   = e_col;
                            v_cmd.seg_cnt   = 12'd1;
                            v_cmd.seg_val   = i_in_data.data_byte;
                            n_col           = e_col + 12'd1;
                            n_pl            = e_pl - 12'd1;
                        end
                        if (v_rbl_dec == '0) begin
                            v_close = 1'b1;
                        end
                    end else if (v_rbl_dec == '0) begin
                        // Zero marker with no count byte left in the row.
                        v_cmd.seg_valid  = 1'b1;
                        v_cmd.seg_col    = e_col;
                        v_cmd.seg_status = ST_NO_COUNT;
                        n_phase          = PH_ERROR;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_rbl = v_rbl_dec;
                    if (v_run != '0) begin
                        v_cmd.seg_valid = 1'b1;
                        v_cmd.seg_col   = e_col;
                        v_cmd.seg_cnt   = v_run;
                    end
                    n_col = e_col + v_run;
                    n_pl  = e_pl - v_run;
                    if (v_rbl_dec == '0) begin
                        v_close = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                default: begin
                end
            endcase

            // Close the row with a transparent pad over what is left of it.
            if (v_close) begin
                v_cmd.close_valid = 1'b1;
                v_cmd.close_col   = n_col;
                v_cmd.close_cnt   = n_pl;
                v_cmd.close_fe    = v_fe;
                n_row             = e_row + 10'd1;
                n_col             = '0;
                n_pl              = '0;
                n_phase           = v_fe ? PH_DONE : PH_LEN_LO;
            end
        end

        o_cmd  = v_cmd;
        o_push = w_accept && (v_cmd.seg_valid || v_cmd.close_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_data_limit   <= RST_DATA_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[11:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[9:0];
                CFG_DATA_LIMIT:   r_data_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_pl      <= '0;
            r_rbl     <= '0;
            r_len_lo  <= '0;
            r_br      <= '0;
            r_bounded <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_col     <= n_col;
            r_pl      <= n_pl;
            r_rbl     <= n_rbl;
            r_len_lo  <= n_len_lo;
            r_br      <= n_br;
            r_bounded <= n_bounded;
        end
    end

endmodule

// File: hw/rtl/zrrle_back.sv
// Output back end: expand queued commands into segment beats through an output register.
module zrrle_back
    import zrrle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic      r_valid, n_valid;
    t_out_beat r_beat, n_beat;
    logic      r_pend, n_pend;
    t_out_beat r_pend_beat, n_pend_beat;
    logic      w_load;

    always_comb begin
        w_load      = !r_valid || !i_out_stall;
        n_valid     = r_valid;
        n_beat      = r_beat;
        n_pend      = r_pend;
        n_pend_beat = r_pend_beat;
        o_pop       = 1'b0;
        if (w_load) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_beat  = r_pend_beat;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_cmd.seg_valid) begin
                    n_beat      = seg_beat(i_cmd);
                    n_pend      = i_cmd.close_valid;
                    n_pend_beat = close_beat(i_cmd);
                end else begin
                    n_beat = close_beat(i_cmd);
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat      <= n_beat;
        r_pend_beat <= n_pend_beat;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_beat;

endmodule

// File: hw/rtl/zero_run_rle_row_decoder.sv
// Top level of the zero-run row-coded frame decoder.
// Takes one encoded byte per beat and emits pixel segments (row, column, count, value) with
// row end, frame end and status flags. Each row opens with a 16-bit little-endian length that
// counts its own two bytes; a nonzero byte is a literal pixel, a zero byte is followed by a
// transparent run count. Pixels past the configured width are dropped, and every row closes
// with a transparent pad beat covering the rest of the row (its count may be zero). Errors
// (short prefix when bounded, bad length, missing count) give one status beat, after which
// bytes are dropped until a beat with frame_start. Rate: the front accepts one byte every
// cycle while the command queue has room; the back emits one beat per cycle while the output
// is not stalled, so a byte that both writes a pixel segment and closes a row needs two
// output beats, absorbed by the QUEUE_DEPTH-entry queue. A result beat passes through the
// command queue and the output register of the back. data_limit is sampled at frame start;
// width and height are read live. Write the registers only while idle.
module zero_run_rle_row_decoder
    import zrrle_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_data,
    // segment output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_data
);

    logic w_push, w_pop, w_empty, w_full;
    t_cmd w_cmd_in, w_cmd_out;

    // Hold off new bytes only while the queue is full.
    assign o_in_stall = w_full;

    zrrle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    zrrle_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    zrrle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/zrrle_checker.sv
// Port-level checker of the row decoder, bound to the top level.
`include "zero_run_rle_row_decoder_defines.svh"

module zrrle_checker
    import zrrle_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    `ZRRLE_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output valid dropped while stalled")

    `ZRRLE_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "output beat changed while stalled")

    `ZRRLE_ASSERT_NOW(a_error_beat_empty, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), !o_out_data.row_end && !o_out_data.frame_end && (o_out_data.pixel_count == 12'd0) && (o_out_data.pixel_value == 8'd0), "error beat carries pixels or row flags")

    `ZRRLE_ASSERT_NOW(a_frame_end_closes_row, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.row_end && (o_out_data.pixel_value == 8'd0), "frame end without row end pad")

    `ZRRLE_ASSERT_NOW(a_literal_single, i_clk, i_rst_n, o_out_valid && (o_out_data.pixel_value != 8'd0), (o_out_data.pixel_count == 12'd1) && !o_out_data.row_end && (o_out_data.status == ST_OK), "literal segment not a single pixel")

endmodule

bind zero_run_rle_row_decoder zrrle_checker u_zrrle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: bench/zero_run_rle_row_decoder_test.sv
// Self-checking testbench of the zero-run row decoder: directed cases, then random frames.
module zero_run_rle_row_decoder_test;
    import zrrle_pkg::*;

    // Result beats trail their byte through a QUEUE_DEPTH-entry queue and an output register,
    // so this many quiet cycles are enough for anything still in flight to show up.
    localparam int          SETTLE_CYCLES = 8;
    // Long receiver hold-off, well past the queue depth, to push stall back to the input.
    localparam int          HOLD_CYCLES   = 48;
    // Cycle bound after which a run counts as hung.
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // Decoder phases of the predictor.
    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_LEN_LO,
        DEC_LEN_HI,
        DEC_DATA,
        DEC_COUNT,
        DEC_DONE,
        DEC_ERROR
    } dec_phase_e;

    // Ways a random frame may be broken.
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_LEN,
        FLAW_NO_COUNT,
        FLAW_CUT,
        FLAW_NOISE
    } flaw_kind_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [23:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    t_in_beat    in_beat   = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_beat;

    // Register copies as the block should hold them.
    logic [11:0] shadow_width  = RST_FRAME_WIDTH;
    logic [9:0]  shadow_height = RST_FRAME_HEIGHT;
    logic [23:0] shadow_limit  = RST_DATA_LIMIT;

    // Predictor state, reset values.
    dec_phase_e  dec_phase      = DEC_IDLE;
    logic [9:0]  dec_row        = '0;
    logic [11:0] dec_col        = '0;
    logic [11:0] dec_left       = '0;
    logic [15:0] dec_row_bytes  = '0;
    logic [7:0]  dec_len_lo     = '0;
    logic [23:0] dec_bytes_left = '0;
    logic        dec_bounded    = 1'b0;

    t_out_beat   pending_segments[$];
    int          sent_bytes     = 0;
    int          check_failures = 0;
    int unsigned cycle_count    = 0;

    // Stimulus shaping.
    logic        quiet         = 1'b0;
    logic        receiver_held = 1'b0;
    int          stall_run     = 0;

    zero_run_rle_row_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one expected segment on the current row.
    function automatic void queue_seg(input logic [11:0] col, input logic [11:0] cnt,
                                      input logic [7:0] val, input logic re,
                                      input logic fe, input logic [1:0] st);
        t_out_beat s;
        s.row_index    = dec_row;
        s.column_start = col;
        s.pixel_count  = cnt;
        s.pixel_value  = val;
        s.row_end      = re;
        s.frame_end    = fe;
        s.status       = st;
        pending_segments.push_back(s);
    endfunction

    // Status beat, then drop everything up to the next frame start.
    function automatic void error_seg(input logic [11:0] col, input logic [1:0] st);
        queue_seg(col, 12'd0, 8'd0, 1'b0, 1'b0, st);
        dec_phase = DEC_ERROR;
    endfunction

    // Pad the rest of the row with transparent pixels and advance to the next row.
    function automatic void close_row_seg();
        logic last;
        last = (int'(dec_row) + 1) >= int'(shadow_height);
        queue_seg(dec_col, dec_left, 8'd0, 1'b1, last, ST_OK);
        dec_row   = dec_row + 10'd1;
        dec_col   = '0;
        dec_left  = '0;
        dec_phase = last ? DEC_DONE : DEC_LEN_LO;
    endfunction

    // Work out the segments that one accepted byte causes.
    function automatic void decode_byte(input t_in_beat beat);
        logic [15:0] row_len;
        logic [11:0] run;
        if (beat.frame_start) begin
            dec_bounded    = shadow_limit != 0;
            dec_bytes_left = shadow_limit;
            dec_row        = '0;
            dec_col        = '0;
            dec_left       = '0;
            dec_row_bytes  = '0;
            dec_phase      = DEC_LEN_LO;
        end
        row_len = {beat.data_byte, dec_len_lo};
        run     = {4'd0, beat.data_byte};
        case (dec_phase)
            DEC_LEN_LO: begin
                if (dec_bounded && dec_bytes_left < 24'(PREFIX_BYTES)) begin
                    error_seg(12'd0, ST_EXHAUSTED);
                end else begin
                    dec_len_lo = beat.data_byte;
                    dec_phase  = DEC_LEN_HI;
                end
            end
            DEC_LEN_HI: begin
                if (row_len < 16'(PREFIX_BYTES) ||
                    (dec_bounded && {8'd0, row_len} > dec_bytes_left)) begin
                    error_seg(12'd0, ST_BAD_LEN);
                end else begin
                    if (dec_bounded) dec_bytes_left = dec_bytes_left - {8'd0, row_len};
                    dec_row_bytes = row_len - 16'(PREFIX_BYTES);
                    dec_left      = shadow_width;
                    dec_col       = '0;
                    if (dec_row_bytes == 0) close_row_seg();
                    else dec_phase = DEC_DATA;
                end
            end
            DEC_DATA: begin
                dec_row_bytes = dec_row_bytes - 16'd1;
                if (beat.data_byte != 8'd0) begin
                    if (dec_left > 0) begin
                        queue_seg(dec_col, 12'd1, beat.data_byte, 1'b0, 1'b0, ST_OK);
                        dec_col  = dec_col + 12'd1;
                        dec_left = dec_left - 12'd1;
                    end
                    if (dec_row_bytes == 0) close_row_seg();
                end else if (dec_row_bytes == 0) begin
                    error_seg(dec_col, ST_NO_COUNT);
                end else begin
                    dec_phase = DEC_COUNT;
                end
            end
            DEC_COUNT: begin
                dec_row_bytes = dec_row_bytes - 16'd1;
                if (run > dec_left) run = dec_left;
                if (run > 0) begin
                    queue_seg(dec_col, run, 8'd0, 1'b0, 1'b0, ST_OK);
                    dec_col  = dec_col + run;
                    dec_left = dec_left - run;
                end
                if (dec_row_bytes == 0) close_row_seg();
                else dec_phase = DEC_DATA;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string seg_text(input t_out_beat s);
        return $sformatf("row %0d col %0d cnt %0d val %02h re %0b fe %0b st %0d",
                         s.row_index, s.column_start, s.pixel_count, s.pixel_value,
                         s.row_end, s.frame_end, s.status);
    endfunction

    // Compare one result beat with the oldest expected segment.
    function automatic void check_segment(input t_out_beat got);
        t_out_beat want;
        if (pending_segments.size() == 0) begin
            if (check_failures < 10) $display("unexpected segment: %s", seg_text(got));
            check_failures++;
        end else begin
            want = pending_segments.pop_front();
            if (got.row_index !== want.row_index || got.column_start !== want.column_start ||
                got.pixel_count !== want.pixel_count || got.pixel_value !== want.pixel_value ||
                got.row_end !== want.row_end || got.frame_end !== want.frame_end ||
                got.status !== want.status) begin
                if (check_failures < 10)
                    $display("segment mismatch\n  expected %s\n  actual   %s",
                             seg_text(want), seg_text(got));
                check_failures++;
            end
        end
    endfunction

    // Predict on the input beat first: a result can never arrive in the cycle
    // its byte is taken, so the expectation is always queued ahead of it.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sent_bytes++;
                decode_byte(in_beat);
            end
            if (out_valid && !out_stall) check_segment(out_beat);
        end
    end

    // Give up on a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments outstanding",
                     cycle_count, pending_segments.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or a long hold-off while receiver_held
    // is up. Change on the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (receiver_held) begin
            out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one byte and hold it until taken. Called and returns on a falling edge;
    // valid stays up afterwards so back-to-back beats need no re-raise.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{data_byte: b, frame_start: fs};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected segment is out, then let the
    // pipeline settle so a byte with no result cannot still be in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_segments.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (index)
            CFG_FRAME_WIDTH:  shadow_width  = value[11:0];
            CFG_FRAME_HEIGHT: shadow_height = value[9:0];
            CFG_DATA_LIMIT:   shadow_limit  = value;
            default: ;
        endcase
    endtask

    // Go idle, then load all three registers.
    task automatic set_geometry(input logic [11:0] width, input logic [9:0] height,
                                input logic [23:0] limit);
        drain();
        write_reg(CFG_FRAME_WIDTH, {12'd0, width});
        write_reg(CFG_FRAME_HEIGHT, {14'd0, height});
        write_reg(CFG_DATA_LIMIT, limit);
    endtask

    // Send one well-formed row of literals and zero runs; with drop_count the
    // row ends on a zero marker that has no count after it.
    task automatic send_row(input bit opens_frame, input int body_len, input bit drop_count);
        logic [7:0]  body[$];
        logic [15:0] row_len;
        int          room;
        room = body_len - (drop_count ? 1 : 0);
        while (body.size() < room) begin
            if (body.size() + 2 <= room && $urandom_range(0, 2) == 0) begin
                body.push_back(8'd0);
                body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 6)));
            end else begin
                body.push_back(8'($urandom_range(1, 255)));
            end
        end
        if (drop_count) body.push_back(8'd0);
        row_len = 16'(body_len + int'(PREFIX_BYTES));
        send_byte(row_len[7:0], opens_frame);
        send_byte(row_len[15:8], 1'b0);
        foreach (body[k]) send_byte(body[k], 1'b0);
    endtask

    // Send a length prefix followed by a few arbitrary bytes, then abandon the row.
    task automatic send_torn_row(input bit opens_frame, input logic [15:0] row_len,
                                 input int tail);
        send_byte(row_len[7:0], opens_frame);
        send_byte(row_len[15:8], 1'b0);
        repeat (tail) send_byte(8'($urandom), 1'b0);
    endtask

    // One frame of random rows; some frames carry one flaw and stop there.
    task automatic send_frame(input int rows);
        int         pick;
        int         flaw_row;
        int         body_len;
        flaw_kind_e flaw;
        pick     = $urandom_range(0, 8);
        flaw     = (pick < 5) ? FLAW_NONE : flaw_kind_e'(pick - 4);
        flaw_row = $urandom_range(0, rows - 1);
        for (int r = 0; r < rows; r++) begin
            body_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30)
                                                   : $urandom_range(0, 8);
            if (r != flaw_row || flaw == FLAW_NONE || flaw == FLAW_NOISE) begin
                send_row(r == 0, body_len, 1'b0);
            end else begin
                case (flaw)
                    FLAW_BAD_LEN:
                        send_torn_row(r == 0, ($urandom_range(0, 1) == 0)
                                      ? 16'($urandom_range(0, 1)) : 16'($urandom), 2);
                    FLAW_NO_COUNT:
                        send_row(r == 0, body_len + 1, 1'b1);
                    default:
                        send_torn_row(r == 0, 16'(body_len + 3), $urandom_range(0, 2));
                endcase
                break;
            end
        end
        if (flaw == FLAW_NOISE)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // Keep sending frames until enough bytes have been taken by the block.
    task automatic run_frames(input int target);
        int first;
        int rows;
        first = sent_bytes;
        while (sent_bytes - first < target) begin
            if (shadow_height <= 10'd4)
                rows = int'(shadow_height) + (($urandom_range(0, 5) == 0) ? 1 : 0);
            else
                rows = $urandom_range(1, 4);
            send_frame(rows);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes before any frame start, then every error status and the
    // silence that follows each one.
    task automatic test_error_paths();
        send_byte(8'hA5, 1'b0);                 // idle: ignored
        set_geometry(12'd640, 10'd480, 24'd1);  // one byte left: no room for a prefix
        send_byte(8'h04, 1'b1);
        send_byte(8'h11, 1'b0);                 // after error: ignored
        set_geometry(12'd640, 10'd480, 24'd5);  // length 6 exceeds five bytes left
        send_byte(8'h06, 1'b1);
        send_byte(8'h00, 1'b0);
        set_geometry(12'd640, 10'd480, 24'd0);  // length 1 is below the prefix size
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b1);                 // zero marker as last byte of its row
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Two-pixel row: literals past the width vanish, a run clipped to nothing
    // gives no segment, and the pad segment closes the frame with count zero.
    task automatic test_row_clipping();
        set_geometry(12'd2, 10'd1, 24'd0);
        send_byte(8'h07, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h42, 1'b0);                 // frame done: ignored
    endtask

    // Width zero clips every pixel; height zero ends the frame on its first row.
    task automatic test_zero_geometry();
        set_geometry(12'd0, 10'd0, 24'd0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b0);
    endtask

    // Largest row length and run, a zero-length run, then a frame start in the
    // middle of the row that silently restarts the decoder.
    task automatic test_restart_mid_frame();
        set_geometry(12'd640, 10'd1023, 24'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Hold the receiver off long enough for the queue to fill and the input
    // to stall, while the sender keeps offering a long row.
    task automatic test_backpressure();
        set_geometry(12'd64, 10'd2, 24'd0);
        fork
            begin
                @(posedge clk);
                receiver_held = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_held = 1'b0;
            end
        join_none
        send_row(1'b1, 24, 1'b0);
        send_row(1'b0, 4, 1'b0);
    endtask

    // Narrow rows and short frames: heavy clipping and frequent frame ends.
    task automatic test_random_narrow();
        repeat (2) begin
            set_geometry(12'($urandom_range(1, 24)), 10'($urandom_range(1, 4)), 24'd0);
            run_frames(20);
        end
    endtask

    // Register extremes: widest and tallest frame with the largest limit,
    // then the one-pixel, one-row frame.
    task automatic test_random_extremes();
        set_geometry(12'd4095, 10'd1023, 24'hFF_FFFF);
        run_frames(25);
        set_geometry(12'd1, 10'd1, 24'd0);
        run_frames(10);
    endtask

    // Small byte budgets so rows run out of data mid-frame.
    task automatic test_random_bounded();
        repeat (3) begin
            set_geometry(12'($urandom_range(1, 16)), 10'($urandom_range(2, 4)),
                         24'($urandom_range(2, 24)));
            run_frames(15);
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_random_steady();
        quiet = 1'b1;
        set_geometry(12'($urandom_range(1, 20)), 10'($urandom_range(1, 3)), 24'd0);
        run_frames(30);
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_error_paths();
        test_row_clipping();
        test_zero_geometry();
        test_restart_mid_frame();
        test_backpressure();
        test_random_narrow();
        test_random_extremes();
        test_random_bounded();
        test_random_steady();
        drain();
        if (check_failures == 0 && pending_segments.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: zero_run_rle_row_decoder.f
+incdir+hw/rtl
hw/rtl/zrrle_pkg.sv
hw/rtl/zrrle_queue.sv
hw/rtl/zrrle_front.sv
hw/rtl/zrrle_back.sv
hw/rtl/zero_run_rle_row_decoder.sv
hw/rtl/zrrle_checker.sv
bench/zero_run_rle_row_decoder_test.sv
